FILE: rtl/nn4d_pkg.sv
// ----------------------------------------------------------------------------
// nn4d_pkg: shared types and constants for the nearest neighbor search
// Field widths of the reference entries, the query and the result, plus
// the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package nn4d_pkg;

	localparam int SCORE_W         = 8;
	localparam int NUM_SCORES      = 4;
	localparam int SCORES_W        = SCORE_W * NUM_SCORES;
	localparam int ID_W            = 10;
	localparam int SLOT_W          = 6;
	localparam int COUNT_W         = 7;
	localparam int SQ_W            = 2 * SCORE_W;
	localparam int DIST_W          = 18;
	localparam int ENTRY_W         = SCORES_W + ID_W;
	localparam int MAX_ENTRIES_DEF = 64;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 40;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WAIT
	} nn4d_state_t;

	typedef logic [SCORES_W-1:0] score_vec_t;

endpackage

`default_nettype wire

FILE: rtl/nn4d_dist.sv
// ----------------------------------------------------------------------------
// nn4d_dist: squared Euclidean distance unit
// Takes one reference vector and the query per cycle while en is high,
// registers the four squared differences and presents their sum combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module nn4d_dist
	import nn4d_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en,
	input  wire score_vec_t        ref_scores,
	input  wire score_vec_t        qry_scores,
	output logic [DIST_W-1:0]      dist_s2
);

	logic [SQ_W-1:0] sq_s2 [NUM_SCORES];
	logic [SQ_W-1:0] sq_c  [NUM_SCORES];

	always_comb begin
		logic [SCORE_W-1:0] a;
		logic [SCORE_W-1:0] b;
		logic [SCORE_W-1:0] d;
		for (int k = 0; k < NUM_SCORES; k++) begin
			a = ref_scores[k*SCORE_W +: SCORE_W];
			b = qry_scores[k*SCORE_W +: SCORE_W];
			d = (a > b) ? (a - b) : (b - a);
			sq_c[k] = SQ_W'(d) * SQ_W'(d);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_SCORES; k++) begin
				sq_s2[k] <= sq_c[k];
			end
		end
	end

	assign dist_s2 = (DIST_W'(sq_s2[0]) + DIST_W'(sq_s2[1]))
		+ (DIST_W'(sq_s2[2]) + DIST_W'(sq_s2[3]));

endmodule

`default_nettype wire

FILE: rtl/nearest_neighbor_4d_search.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_4d_search: one-nearest-neighbor search over a table
// Holds reference vectors of four 8-bit scores and an identifier, and
// answers queries with the closest entry by squared Euclidean distance.
// ----------------------------------------------------------------------------
// Usage:
// A beat on the s_ channel with s_tuser = 0 loads one table entry and gives
// no result. A beat with s_tuser = 1 is a query; it scans slots 0 .. n-1,
// where n is cfg_wdata as last written (clamped to MAX_ENTRIES), one slot
// per cycle through the memory read port and the shared distance unit.
// From acceptance until its result is written to the output register,
// s_tready stays low. With an empty table the query skips the scan and the
// result (found = 0, all fields zero) is written once the output register
// is free. Ties go to the lowest slot. The result sits in an output
// register, so new beats are accepted while a result waits; a finished
// query stays in ST_WAIT until that register frees.
// Reset clears the entry count, the sequencer and the output; table contents
// are undefined until loaded. cfg_we may only be used while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_4d_search
	import nn4d_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [COUNT_W-1:0]    cfg_wdata,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// entry_index, item_id, score_a, score_b, score_c, score_d
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	// operation
	input  wire logic                  s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// nearest_index, nearest_id, distance_sq, zero fill
	output logic [M_TDATA_W-1:0]       m_tdata,
	// found
	output logic                       m_tuser
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = ($clog2(MAX_ENTRIES + 1) > COUNT_W) ?
		$clog2(MAX_ENTRIES + 1) : COUNT_W;
	localparam int PAD_W = M_TDATA_W - (SLOT_W + ID_W + DIST_W);

	// Input beat fields.
	logic [SLOT_W-1:0] in_slot;
	logic [ID_W-1:0]   in_id;
	score_vec_t        in_scores;
	assign in_slot   = s_tdata[SLOT_W-1:0];
	assign in_id     = s_tdata[SLOT_W +: ID_W];
	assign in_scores = s_tdata[SLOT_W+ID_W +: SCORES_W];

	logic [COUNT_W-1:0] count_q;
	nn4d_state_t        state_q, state_d;
	logic [CNT_W-1:0]   n_q;
	logic [IDX_W-1:0]   rd_idx_q;
	score_vec_t         qry_q;

	logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
	logic [ENTRY_W-1:0] rdata_s1;
	logic [IDX_W-1:0]   idx_s1, idx_s2;
	logic [ID_W-1:0]    id_s2;
	logic               v_s1, v_s2;
	logic [DIST_W-1:0]  dist_s2;

	logic               have_q;
	logic [DIST_W-1:0]  best_d_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [ID_W-1:0]    best_id_q;

	logic               out_valid_q;
	logic               out_found_q;
	logic [M_TDATA_W-1:0] out_data_q;

	logic               in_beat, is_query, is_load, issue, last_issue, out_free;
	logic [CNT_W-1:0]   n_clamp;

	assign s_tready   = (state_q == ST_IDLE);
	assign in_beat    = s_tvalid && s_tready;
	assign is_query   = in_beat && s_tuser;
	assign is_load    = in_beat && !s_tuser;
	assign issue      = (state_q == ST_SCAN);
	assign last_issue = issue && (CNT_W'(rd_idx_q) == n_q - CNT_W'(1));
	assign out_free   = !out_valid_q || m_tready;
	assign n_clamp    = (CNT_W'(count_q) > CNT_W'(MAX_ENTRIES)) ?
		CNT_W'(MAX_ENTRIES) : CNT_W'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (is_query) begin
					state_d = (n_clamp == '0) ? ST_WAIT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			n_q      <= '0;
		end else if (is_query) begin
			rd_idx_q <= '0;
			n_q      <= n_clamp;
		end else if (issue) begin
			rd_idx_q <= rd_idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (is_query) begin
			qry_q <= in_scores;
		end
	end

	// Reference table: one write port for loads, one registered read port.
	always_ff @(posedge clk) begin
		if (is_load && (CNT_W'(in_slot) < CNT_W'(MAX_ENTRIES))) begin
			mem[IDX_W'(in_slot)] <= {in_id, in_scores};
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= mem[rd_idx_q];
			idx_s1   <= rd_idx_q;
		end
		if (v_s1) begin
			idx_s2 <= idx_s1;
			id_s2  <= rdata_s1[SCORES_W +: ID_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	nn4d_dist u_dist (
		.clk        (clk),
		.en         (v_s1),
		.ref_scores (rdata_s1[SCORES_W-1:0]),
		.qry_scores (qry_q),
		.dist_s2    (dist_s2)
	);

	// Running minimum; a strict compare keeps the first slot on ties.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			best_d_q   <= '0;
			best_idx_q <= '0;
			best_id_q  <= '0;
		end else if (is_query) begin
			have_q     <= 1'b0;
			best_d_q   <= '0;
			best_idx_q <= '0;
			best_id_q  <= '0;
		end else if (v_s2 && (!have_q || (dist_s2 < best_d_q))) begin
			have_q     <= 1'b1;
			best_d_q   <= dist_s2;
			best_idx_q <= idx_s2;
			best_id_q  <= id_s2;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_data_q  <= '0;
		end else if ((state_q == ST_WAIT) && out_free) begin
			out_valid_q <= 1'b1;
			out_found_q <= have_q;
			out_data_q  <= {PAD_W'(0), best_d_q, best_id_q, SLOT_W'(best_idx_q)};
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_found_q;

	// Checks.
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!v_s1 && !v_s2))
		else $error("distance pipeline busy while idle");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CNT_W'(rd_idx_q) < n_q))
		else $error("scan address beyond entry count");

	a_empty_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("empty search result carries nonzero fields");

	a_empty_skips_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(is_query && (n_clamp == '0)) |=> (state_q == ST_WAIT))
		else $error("empty search entered scan");

endmodule

`default_nettype wire
